// ===== sv/sced_pkg.sv =====
// Shared types and constants for the sensor change event detector.
// Used by every module of the block; depends on nothing else.
package sced_pkg;

    localparam int DIST_BITS_DEF = 16;
    localparam int THR_BITS      = 16;
    localparam int CAP_BITS      = 2;
    localparam int QUEUE_DEPTH   = 4;
    localparam int ADDR_BITS     = 3;
    localparam int DATA_BITS     = 32;

    localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 16'd50;
    localparam logic [CAP_BITS-1:0] CAP_RESET       = 2'd3;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_CAP       = 1'b1;

    typedef enum logic [1:0] {
        EV_IR1  = 2'd0,
        EV_IR2  = 2'd1,
        EV_DIST = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic [2:0] kept;
        logic       lvl1;
        logic       lvl2;
    } sced_ctrl_t;

    localparam int CTRL_BITS = $bits(sced_ctrl_t);

endpackage

// ===== sv/sced_front.sv =====
// Front end: accepts snapshots, tracks presence and reference state, and
// classifies each snapshot into a record of events to emit.
// Depends on sced_pkg.
module sced_front #(
    parameter int DIST_BITS = sced_pkg::DIST_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          q_full,
    input  logic                          presence_a,
    input  logic                          presence_b,
    input  logic                          distance_valid,
    input  logic [DIST_BITS-1:0]          distance,
    input  logic [sced_pkg::THR_BITS-1:0] distance_threshold,
    input  logic [sced_pkg::CAP_BITS-1:0] event_cap,
    output logic                          rec_push,
    output sced_pkg::sced_ctrl_t          rec_ctrl,
    output logic [DIST_BITS-1:0]          rec_from,
    output logic [DIST_BITS-1:0]          rec_to
);
    import sced_pkg::*;

    localparam int CMP_BITS = (DIST_BITS > THR_BITS) ? DIST_BITS : THR_BITS;

    logic                 ir1_seen_reg, ir1_seen_next;
    logic                 ir1_level_reg, ir1_level_next;
    logic                 ir2_seen_reg, ir2_seen_next;
    logic                 ir2_level_reg, ir2_level_next;
    logic                 dist_seen_reg, dist_seen_next;
    logic [DIST_BITS-1:0] ref_reg, ref_next;

    logic                 accept;
    logic [2:0]           hit;
    logic [2:0]           kept;
    logic [DIST_BITS-1:0] delta;
    logic [CMP_BITS-1:0]  delta_ext;
    logic [CMP_BITS-1:0]  thr_ext;

    assign accept = push && !q_full;

    always_comb
    begin
        logic [CAP_BITS-1:0] cnt;
        delta     = (distance >= ref_reg) ? (distance - ref_reg)
                                          : (ref_reg - distance);
        delta_ext = CMP_BITS'(delta);
        thr_ext   = CMP_BITS'(distance_threshold);
        hit[0]    = !ir1_seen_reg || (presence_a != ir1_level_reg);
        hit[1]    = !ir2_seen_reg || (presence_b != ir2_level_reg);
        hit[2]    = distance_valid && dist_seen_reg && (delta_ext >= thr_ext);
        cnt       = '0;
        kept      = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (hit[i] && (cnt < event_cap))
            begin
                kept[i] = 1'b1;
                cnt     = cnt + 1'b1;
            end
        end
    end

    always_comb
    begin
        ir1_seen_next  = ir1_seen_reg;
        ir1_level_next = ir1_level_reg;
        ir2_seen_next  = ir2_seen_reg;
        ir2_level_next = ir2_level_reg;
        dist_seen_next = dist_seen_reg;
        ref_next       = ref_reg;
        if (accept)
        begin
            ir1_seen_next  = 1'b1;
            ir1_level_next = presence_a;
            ir2_seen_next  = 1'b1;
            ir2_level_next = presence_b;
            if (distance_valid && (!dist_seen_reg || hit[2]))
            begin
                dist_seen_next = 1'b1;
                ref_next       = distance;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir1_seen_reg  <= 1'b0;
            ir1_level_reg <= 1'b0;
            ir2_seen_reg  <= 1'b0;
            ir2_level_reg <= 1'b0;
            dist_seen_reg <= 1'b0;
            ref_reg       <= '0;
        end
        else
        begin
            ir1_seen_reg  <= ir1_seen_next;
            ir1_level_reg <= ir1_level_next;
            ir2_seen_reg  <= ir2_seen_next;
            ir2_level_reg <= ir2_level_next;
            dist_seen_reg <= dist_seen_next;
            ref_reg       <= ref_next;
        end
    end

    assign rec_push = accept && (kept != 3'b000);
    assign rec_ctrl = {kept, presence_a, presence_b};
    assign rec_from = ref_reg;
    assign rec_to   = distance;

endmodule

// ===== sv/sced_queue.sv =====
// Short record queue between the front end and the event emitter.
// Depends on sced_pkg for its depth.
module sced_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sced_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             q_full,
    output logic             q_empty
);
    import sced_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_wr;
    logic                do_rd;

    assign q_full  = (count_reg == CNT_BITS'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/sced_back.sv =====
// Back end: expands each queued record into its events, one per cycle while the output is not
// stalled, into an output register. Depends on sced_pkg.
module sced_back #(
    parameter int DIST_BITS = sced_pkg::DIST_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  sced_pkg::sced_ctrl_t head_ctrl,
    input  logic [DIST_BITS-1:0] head_from,
    input  logic [DIST_BITS-1:0] head_to,
    output logic                 q_pop,
    input  logic                 pop,
    output logic                 empty,
    output logic [1:0]           event_kind,
    output logic                 level,
    output logic [DIST_BITS-1:0] from_mm,
    output logic [DIST_BITS-1:0] to_mm,
    output logic                 last
);
    import sced_pkg::*;

    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           done_reg, done_next;
    event_kind_t          kind_reg;
    logic                 level_reg;
    logic [DIST_BITS-1:0] from_reg;
    logic [DIST_BITS-1:0] to_reg;
    logic                 last_reg;

    logic                 emit;
    logic [2:0]           rem;
    logic [2:0]           pick;
    logic [2:0]           rest;
    event_kind_t          kind_sel;
    logic                 level_sel;
    logic [DIST_BITS-1:0] from_sel;
    logic [DIST_BITS-1:0] to_sel;

    assign emit = !q_empty && (!out_valid_reg || pop);
    assign rem  = head_ctrl.kept & ~done_reg;

    always_comb
    begin
        pick      = 3'b100;
        kind_sel  = EV_DIST;
        level_sel = 1'b0;
        from_sel  = head_from;
        to_sel    = head_to;
        if (rem[0])
        begin
            pick      = 3'b001;
            kind_sel  = EV_IR1;
            level_sel = head_ctrl.lvl1;
            from_sel  = '0;
            to_sel    = '0;
        end
        else if (rem[1])
        begin
            pick      = 3'b010;
            kind_sel  = EV_IR2;
            level_sel = head_ctrl.lvl2;
            from_sel  = '0;
            to_sel    = '0;
        end
    end

    assign rest  = rem & ~pick;
    assign q_pop = emit && (rest == 3'b000);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        done_next      = done_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            done_next      = (rest == 3'b000) ? 3'b000 : (done_reg | pick);
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg  <= kind_sel;
            level_reg <= level_sel;
            from_reg  <= from_sel;
            to_reg    <= to_sel;
            last_reg  <= (rest == 3'b000);
        end
    end

    assign empty      = !out_valid_reg;
    assign event_kind = kind_reg;
    assign level      = level_reg;
    assign from_mm    = from_reg;
    assign to_mm      = to_reg;
    assign last       = last_reg;

endmodule

// ===== sv/sensor_change_event_detector_core.sv =====
// Top level of the sensor change event detector: configuration registers,
// front end, record queue and event emitter.
// Depends on sced_pkg, sced_front, sced_queue and sced_back.
//
//  Channel     Handshake                 Payload
//  snapshot    push / full               presence_a, presence_b, distance_valid, distance
//  event       pop / empty               event_kind, level, from_mm, to_mm, last
//  config      psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// A snapshot is taken whenever the record queue has room; its record, if any, is written to the
// queue, and its first event is then registered into the output register. Events leave one beat
// per cycle while pop keeps up, so a snapshot with k events occupies the output for k beats (up
// to three). The four-entry record queue lets the front keep accepting while the output stalls.
// Reset clears control state and loads the register reset values; there is no clearing pass.
module sensor_change_event_detector_core #(
    parameter int DIST_BITS = sced_pkg::DIST_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           presence_a,
    input  logic                           presence_b,
    input  logic                           distance_valid,
    input  logic [DIST_BITS-1:0]           distance,
    input  logic                           pop,
    output logic                           empty,
    output logic [1:0]                     event_kind,
    output logic                           level,
    output logic [DIST_BITS-1:0]           from_mm,
    output logic [DIST_BITS-1:0]           to_mm,
    output logic                           last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sced_pkg::ADDR_BITS-1:0] paddr,
    input  logic [sced_pkg::DATA_BITS-1:0] pwdata,
    output logic [sced_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);
    import sced_pkg::*;

    localparam int REC_BITS = CTRL_BITS + 2 * DIST_BITS;

    logic [THR_BITS-1:0]  thr_reg, thr_next;
    logic [CAP_BITS-1:0]  cap_reg, cap_next;
    logic                 cfg_wr;

    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    logic                 rec_push;
    sced_ctrl_t           rec_ctrl;
    logic [DIST_BITS-1:0] rec_from;
    logic [DIST_BITS-1:0] rec_to;
    logic [REC_BITS-1:0]  head_data;
    sced_ctrl_t           head_ctrl;
    logic [DIST_BITS-1:0] head_from;
    logic [DIST_BITS-1:0] head_to;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        thr_next = thr_reg;
        cap_next = cap_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_THRESHOLD: thr_next = pwdata[THR_BITS-1:0];
                REG_CAP:       cap_next = pwdata[CAP_BITS-1:0];
                default:       thr_next = thr_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_THRESHOLD: prdata = DATA_BITS'(thr_reg);
            REG_CAP:       prdata = DATA_BITS'(cap_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
            cap_reg <= CAP_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
            cap_reg <= cap_next;
        end
    end

    assign full = q_full;

    sced_front #(
        .DIST_BITS (DIST_BITS)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .q_full             (q_full),
        .presence_a         (presence_a),
        .presence_b         (presence_b),
        .distance_valid     (distance_valid),
        .distance           (distance),
        .distance_threshold (thr_reg),
        .event_cap          (cap_reg),
        .rec_push           (rec_push),
        .rec_ctrl           (rec_ctrl),
        .rec_from           (rec_from),
        .rec_to             (rec_to)
    );

    sced_queue #(
        .WIDTH (REC_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data ({rec_ctrl, rec_from, rec_to}),
        .rd_en   (q_pop),
        .rd_data (head_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    assign head_ctrl = head_data[REC_BITS-1 -: CTRL_BITS];
    assign head_from = head_data[2*DIST_BITS-1 -: DIST_BITS];
    assign head_to   = head_data[DIST_BITS-1:0];

    sced_back #(
        .DIST_BITS (DIST_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head_ctrl  (head_ctrl),
        .head_from  (head_from),
        .head_to    (head_to),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .event_kind (event_kind),
        .level      (level),
        .from_mm    (from_mm),
        .to_mm      (to_mm),
        .last       (last)
    );

endmodule
